// File: sv/fcbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcbt_pkg: shared types and constants for the frustum box test unit
// Command codes, sequencer states and plane extraction tables.
// ----------------------------------------------------------------------------
package fcbt_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_VIEW = 2'd0,
    CMD_LOAD_PROJ = 2'd1,
    CMD_BUILD     = 2'd2,
    CMD_TEST      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_PLANE,
    ST_TEST,
    ST_DONE
  } state_t;

  localparam int ElemW  = 32;
  localparam int CoefW  = 40;
  localparam int CoordW = 24;
  // exact clip accumulator: four 64-bit products
  localparam int AccW   = 66;
  // plane value: three 64-bit terms plus a 40-bit d
  localparam int SumW   = 67;

  localparam logic signed [CoefW-1:0] CoefMax = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic signed [CoefW-1:0] CoefMin = {1'b1, {(CoefW-1){1'b0}}};

  // clip column used by a plane: left, right, top, bottom, near, far
  function automatic logic [1:0] plane_col(input logic [2:0] n);
    case (n)
      3'd0, 3'd1: plane_col = 2'd0;
      3'd2, 3'd3: plane_col = 2'd1;
      default:    plane_col = 2'd2;
    endcase
  endfunction

  // plane takes w minus the column element
  function automatic logic plane_neg(input logic [2:0] n);
    case (n)
      3'd1, 3'd2, 3'd5: plane_neg = 1'b1;
      default:          plane_neg = 1'b0;
    endcase
  endfunction

endpackage
`default_nettype wire

// File: sv/frustum_cull_box_test_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_cull_box_test_unit: frustum plane build and box visibility test
// Loads two Q16.16 matrices, builds six planes, tests integer boxes.
// ----------------------------------------------------------------------------
// Load words are taken one per cycle and may come back to back. A build
// walks the 16 clip elements with one 32x32 multiplier, one product per
// cycle, then waits for the last clip element to be stored and writes the
// 24 coefficients one per cycle; in_ready stays low until the build ends.
// A box test issues one plane per cycle into a three-multiplier evaluator
// with registered products: the in_view word waits in the output register
// until taken, so no new box is taken before the last result is taken.
// in_ready is low while any word is in work or its result is held.
module frustum_cull_box_test_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [1:0]         in_cmd,
  input  wire  [3:0]         in_elem_index,
  input  wire  signed [31:0] in_elem_value,
  input  wire  signed [23:0] in_min_x,
  input  wire  signed [23:0] in_min_y,
  input  wire  signed [23:0] in_min_z,
  input  wire  signed [23:0] in_max_x,
  input  wire  signed [23:0] in_max_y,
  input  wire  signed [23:0] in_max_z,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               out_in_view
);

  localparam int CW = fcbt_pkg::CoefW;
  localparam int EW = fcbt_pkg::ElemW;
  localparam int AW = fcbt_pkg::AccW;

  fcbt_pkg::state_t state_r, state_nxt;

  logic signed [EW-1:0]  view_r [16];
  logic signed [EW-1:0]  proj_r [16];
  logic signed [AW-1:0]  clip_r [16];
  logic signed [CW-1:0]  coef_r [24];

  logic signed [23:0] mn_x_r, mn_y_r, mn_z_r, mx_x_r, mx_y_r, mx_z_r;

  // clip phase counter: element (4 bits) and k (2 bits)
  logic [5:0] step_r, step_nxt;
  logic       prod_v_r;
  logic       prod_last_r;
  logic [3:0] prod_e_r;
  logic signed [63:0] prod_r;
  logic signed [AW-1:0] acc_r;
  // plane phase: coefficient index
  logic [4:0] ci_r, ci_nxt;
  // test phase: plane issue count and result tracking
  logic [3:0] tc_r, tc_nxt;
  logic       view_ok_r, view_ok_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       in_fire;
  logic       pass;
  logic [2:0] pl_n;
  logic [1:0] pl_j;
  logic [2:0] tn;
  logic signed [AW:0] pl_w, pl_e, pl_v;

  assign in_fire     = in_valid && in_ready;
  assign in_ready    = (state_r == fcbt_pkg::ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_in_view = view_ok_r;

  // capture matrix loads and box operands
  always_ff @(posedge clk) begin
    if (in_fire && in_cmd == fcbt_pkg::CMD_LOAD_VIEW) begin
      view_r[in_elem_index] <= in_elem_value;
    end
    if (in_fire && in_cmd == fcbt_pkg::CMD_LOAD_PROJ) begin
      proj_r[in_elem_index] <= in_elem_value;
    end
    if (in_fire && in_cmd == fcbt_pkg::CMD_TEST) begin
      mn_x_r <= in_min_x; mn_y_r <= in_min_y; mn_z_r <= in_min_z;
      mx_x_r <= in_max_x; mx_y_r <= in_max_y; mx_z_r <= in_max_z;
    end
  end

  // shared multiplier: view[r][k] * proj[k][c], registered
  always_ff @(posedge clk) begin
    prod_r   <= 64'(view_r[{step_r[5:4], step_r[1:0]}]) *
                64'(proj_r[{step_r[1:0], step_r[3:2]}]);
    prod_e_r <= step_r[5:2];
    prod_last_r <= (step_r[1:0] == 2'd3);
  end

  // accumulate and store clip element, floored to Q.16
  always_ff @(posedge clk) begin
    if (prod_v_r) begin
      if (prod_last_r) begin
        clip_r[prod_e_r] <= (acc_r + AW'(prod_r)) >>> 16;
        acc_r <= '0;
      end else begin
        acc_r <= acc_r + AW'(prod_r);
      end
    end else if (state_r == fcbt_pkg::ST_IDLE) begin
      acc_r <= '0;
    end
  end

  // build one plane coefficient per cycle with saturation
  assign pl_n = 3'(ci_r >> 2);
  assign pl_j = ci_r[1:0];
  always_comb begin
    pl_w = (AW+1)'(clip_r[{pl_j, 2'd3}]);
    pl_e = (AW+1)'(clip_r[{pl_j, fcbt_pkg::plane_col(pl_n)}]);
    pl_v = fcbt_pkg::plane_neg(pl_n) ? pl_w - pl_e : pl_w + pl_e;
  end
  always_ff @(posedge clk) begin
    if (state_r == fcbt_pkg::ST_PLANE) begin
      if (pl_v > (AW+1)'(fcbt_pkg::CoefMax)) begin
        coef_r[ci_r] <= fcbt_pkg::CoefMax;
      end else if (pl_v < (AW+1)'(fcbt_pkg::CoefMin)) begin
        coef_r[ci_r] <= fcbt_pkg::CoefMin;
      end else begin
        coef_r[ci_r] <= CW'(pl_v);
      end
    end
  end

  // plane evaluator, one plane issued per cycle
  assign tn = (tc_r < 4'd6) ? tc_r[2:0] : 3'd5;
  fcbt_plane_eval u_eval (
    .clk    (clk),
    .coef_a (coef_r[{tn, 2'd0}]),
    .coef_b (coef_r[{tn, 2'd1}]),
    .coef_c (coef_r[{tn, 2'd2}]),
    .coef_d (coef_r[{tn, 2'd3}]),
    .mn_x   (mn_x_r), .mn_y (mn_y_r), .mn_z (mn_z_r),
    .mx_x   (mx_x_r), .mx_y (mx_y_r), .mx_z (mx_z_r),
    .pass   (pass)
  );

  // sequencer state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fcbt_pkg::ST_IDLE;
      step_r      <= '0;
      ci_r        <= '0;
      tc_r        <= '0;
      view_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
      prod_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      ci_r        <= ci_nxt;
      tc_r        <= tc_nxt;
      view_ok_r   <= view_ok_nxt;
      out_valid_r <= out_valid_nxt;
      prod_v_r    <= (state_r == fcbt_pkg::ST_CLIP);
    end
  end

  // next state: advance counters, drop result once taken
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    ci_nxt        = ci_r;
    tc_nxt        = tc_r;
    view_ok_nxt   = view_ok_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      fcbt_pkg::ST_IDLE: begin
        if (in_fire && in_cmd == fcbt_pkg::CMD_BUILD) begin
          state_nxt = fcbt_pkg::ST_CLIP;
          step_nxt  = '0;
        end else if (in_fire && in_cmd == fcbt_pkg::CMD_TEST) begin
          state_nxt   = fcbt_pkg::ST_TEST;
          tc_nxt      = '0;
          view_ok_nxt = 1'b1;
        end
      end
      fcbt_pkg::ST_CLIP: begin
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd63) begin
          state_nxt = fcbt_pkg::ST_PLANE;
          ci_nxt    = '0;
        end
      end
      fcbt_pkg::ST_PLANE: begin
        // wait for the last clip write before the first read
        if (prod_v_r) begin
          ci_nxt = '0;
        end else begin
          ci_nxt = ci_r + 5'd1;
          if (ci_r == 5'd23) begin
            state_nxt = fcbt_pkg::ST_IDLE;
          end
        end
      end
      fcbt_pkg::ST_TEST: begin
        tc_nxt = tc_r + 4'd1;
        if (tc_r >= 4'd1 && !pass) begin
          view_ok_nxt = 1'b0;
        end
        if (tc_r == 4'd6) begin
          state_nxt     = fcbt_pkg::ST_DONE;
          out_valid_nxt = 1'b1;
        end
      end
      fcbt_pkg::ST_DONE: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = fcbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fcbt_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a result is only held in the done state
  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == fcbt_pkg::ST_DONE)
    else $error("result valid outside done state");

  // no new word while a result waits
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result held");

  // a box test reaches the done state with its result valid
  a_test_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd == fcbt_pkg::CMD_TEST) |=> ##7 out_valid)
    else $error("box test length wrong");
`endif

endmodule
`default_nettype wire

// File: sv/fcbt_plane_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fcbt_plane_eval: one plane against one box, registered products then sum
// Picks the maximizing corner per axis, multiplies, then sums with d.
// ----------------------------------------------------------------------------
module fcbt_plane_eval (
  input  wire                                  clk,
  input  wire  logic signed [fcbt_pkg::CoefW-1:0]  coef_a,
  input  wire  logic signed [fcbt_pkg::CoefW-1:0]  coef_b,
  input  wire  logic signed [fcbt_pkg::CoefW-1:0]  coef_c,
  input  wire  logic signed [fcbt_pkg::CoefW-1:0]  coef_d,
  input  wire  logic signed [fcbt_pkg::CoordW-1:0] mn_x,
  input  wire  logic signed [fcbt_pkg::CoordW-1:0] mn_y,
  input  wire  logic signed [fcbt_pkg::CoordW-1:0] mn_z,
  input  wire  logic signed [fcbt_pkg::CoordW-1:0] mx_x,
  input  wire  logic signed [fcbt_pkg::CoordW-1:0] mx_y,
  input  wire  logic signed [fcbt_pkg::CoordW-1:0] mx_z,
  output logic                                 pass
);

  localparam int PW = fcbt_pkg::CoefW + fcbt_pkg::CoordW;

  logic signed [PW-1:0]            tx_r, ty_r, tz_r;
  logic signed [fcbt_pkg::CoefW-1:0] d_r;
  logic                            zero_r;
  logic signed [fcbt_pkg::CoordW-1:0] sx, sy, sz;
  logic signed [fcbt_pkg::SumW-1:0]   sum;

  // choose max corner: larger coordinate when coefficient is nonnegative
  always_comb begin
    sx = coef_a[fcbt_pkg::CoefW-1] ? (mn_x < mx_x ? mn_x : mx_x) : (mn_x > mx_x ? mn_x : mx_x);
    sy = coef_b[fcbt_pkg::CoefW-1] ? (mn_y < mx_y ? mn_y : mx_y) : (mn_y > mx_y ? mn_y : mx_y);
    sz = coef_c[fcbt_pkg::CoefW-1] ? (mn_z < mx_z ? mn_z : mx_z) : (mn_z > mx_z ? mn_z : mx_z);
  end

  // register the three products
  always_ff @(posedge clk) begin
    tx_r   <= coef_a * sx;
    ty_r   <= coef_b * sy;
    tz_r   <= coef_c * sz;
    d_r    <= coef_d;
    zero_r <= (coef_a == '0) && (coef_b == '0) && (coef_c == '0);
  end

  // sum and sign test
  always_comb begin
    sum  = fcbt_pkg::SumW'(tx_r) + fcbt_pkg::SumW'(ty_r) + fcbt_pkg::SumW'(tz_r)
         + fcbt_pkg::SumW'(d_r);
    pass = !zero_r && (sum > 0);
  end

endmodule
`default_nettype wire
